### rtl/apl_pkg.sv
// apl_pkg: shared types and constants of the audio peak limiter
// beat structs, register codes, fixed-point constants and multiplier request type
// no dependencies
package apl_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int ENV_SHIFT   = 32 - SAMPLE_BITS;
    localparam int COEF_MAX    = 24;
    localparam int APB_ADDR_W  = 4;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = COEF_MAX + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_ATTACK    = 2'd1;
    localparam logic [1:0] REG_RELEASE   = 2'd2;

    localparam logic signed [15:0] THR_RESET     = -16'sd256;
    localparam logic [COEF_MAX-1:0] ATTACK_RESET  = 24'd64186;
    localparam logic [COEF_MAX-1:0] RELEASE_RESET = 24'd65522;

    localparam logic [31:0]        ENV_FLOOR    = 32'd2;
    localparam logic signed [17:0] DB_FLOOR     = -18'sd25600;
    localparam logic [14:0]        GAIN_MIN_MAG = 15'd24576;
    localparam logic [15:0]        LIN_UNITY    = 16'd32768;

    localparam logic [MUL_B_W-1:0] LOG_CORR        = 25'd22708;
    localparam logic [MUL_B_W-1:0] DB_PER_LOG2     = 25'd394566;
    localparam logic [MUL_B_W-1:0] SLOPE_Q16       = 25'd62259;
    localparam logic [MUL_B_W-1:0] LOG2_10_OVER_20 = 25'd10885;
    localparam logic [MUL_B_W-1:0] EXP_CORR        = 25'd22486;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          block_end;
    } apl_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic signed [15:0]            gain_db;
        logic                          block_end_out;
    } apl_out_t;

    typedef struct packed {
        logic               en;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } apl_mul_req_t;

endpackage

### rtl/apl_mul.sv
// apl_mul: shared unsigned multiplier with registered product
// loads a new product whenever the sequencer requests one
// depends on apl_pkg
module apl_mul (
    input  logic                             aclk,
    input  apl_pkg::apl_mul_req_t            req,
    output logic [apl_pkg::MUL_P_W-1:0]      prod
);
    import apl_pkg::*;

    logic [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (req.en) begin
            prod_reg <= MUL_P_W'(req.a) * MUL_P_W'(req.b);
        end
    end

    assign prod = prod_reg;

endmodule

### rtl/apl_regs.sv
// apl_regs: apb configuration registers of the peak limiter
// threshold and the two envelope coefficients, readable and writable
// depends on apl_pkg
module apl_regs #(
    parameter int COEF_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [apl_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic signed [15:0]              threshold,
    output logic [COEF_BITS-1:0]            attack_coef,
    output logic [COEF_BITS-1:0]            release_coef
);
    import apl_pkg::*;

    logic signed [15:0]   thr_reg;
    logic [COEF_BITS-1:0] attack_reg;
    logic [COEF_BITS-1:0] release_reg;
    logic [COEF_MAX-1:0]  wr_coef;
    logic                 wr_en;

    assign wr_en   = psel && penable && pwrite;
    assign wr_coef = {{(COEF_MAX-16){1'b0}}, pwdata[15:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg     <= THR_RESET;
            attack_reg  <= ATTACK_RESET[COEF_BITS-1:0];
            release_reg <= RELEASE_RESET[COEF_BITS-1:0];
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_THRESHOLD: thr_reg     <= $signed(pwdata[15:0]);
                REG_ATTACK:    attack_reg  <= wr_coef[COEF_BITS-1:0];
                REG_RELEASE:   release_reg <= wr_coef[COEF_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_THRESHOLD: prdata = {{16{thr_reg[15]}}, thr_reg};
            REG_ATTACK:    prdata = 32'(attack_reg);
            REG_RELEASE:   prdata = 32'(release_reg);
            default:       prdata = 32'd0;
        endcase
    end

    assign pready       = 1'b1;
    assign threshold    = thr_reg;
    assign attack_coef  = attack_reg;
    assign release_coef = release_reg;

endmodule

### rtl/apl_seq.sv
// apl_seq: sequencer and datapath registers of the peak limiter
// steps envelope, log, gain, exp and scaling through the shared multiplier
// depends on apl_pkg and the product of apl_mul
module apl_seq #(
    parameter int COEF_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  apl_pkg::apl_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output apl_pkg::apl_out_t               m_data,
    input  logic signed [15:0]              threshold,
    input  logic [COEF_BITS-1:0]            attack_coef,
    input  logic [COEF_BITS-1:0]            release_coef,
    output apl_pkg::apl_mul_req_t           mul_req,
    input  logic [apl_pkg::MUL_P_W-1:0]     prod
);
    import apl_pkg::*;

    localparam int SB = SAMPLE_BITS;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_ENV0  = 5'd1;
    localparam logic [4:0] S_ENV1  = 5'd2;
    localparam logic [4:0] S_ENV2  = 5'd3;
    localparam logic [4:0] S_NORM  = 5'd4;
    localparam logic [4:0] S_LOG0  = 5'd5;
    localparam logic [4:0] S_LOG1  = 5'd6;
    localparam logic [4:0] S_LOG2  = 5'd7;
    localparam logic [4:0] S_LOG3  = 5'd8;
    localparam logic [4:0] S_LOG4  = 5'd9;
    localparam logic [4:0] S_GAIN0 = 5'd10;
    localparam logic [4:0] S_GAIN1 = 5'd11;
    localparam logic [4:0] S_GAIN2 = 5'd12;
    localparam logic [4:0] S_EXP0  = 5'd13;
    localparam logic [4:0] S_EXP1  = 5'd14;
    localparam logic [4:0] S_EXP2  = 5'd15;
    localparam logic [4:0] S_EXP3  = 5'd16;
    localparam logic [4:0] S_EXP4  = 5'd17;
    localparam logic [4:0] S_OUT0  = 5'd18;
    localparam logic [4:0] S_OUT1  = 5'd19;

    logic [4:0]          state_reg, state_next;
    logic [31:0]         env_reg, env_next;
    logic                m_valid_reg, m_valid_next;
    apl_out_t            m_data_reg, m_data_next;

    logic                sign_reg, sign_next;
    logic [SB-1:0]       mag_reg, mag_next;
    logic [31:0]         x_reg, x_next;
    logic                blk_reg, blk_next;
    logic [MUL_P_W-1:0]  acc_reg, acc_next;
    logic [31:0]         w_reg, w_next;
    logic [4:0]          p_reg, p_next;
    logic [2:0]          k_reg, k_next;
    logic [20:0]         arg_reg, arg_next;
    logic signed [17:0]  db_reg, db_next;
    logic signed [15:0]  gain_reg, gain_next;
    logic [3:0]          n_reg, n_next;
    logic [15:0]         lin_reg, lin_next;

    logic [COEF_BITS-1:0] coef_sel;
    logic [MUL_B_W-1:0]   coef_one;
    logic [MUL_B_W-1:0]   coef_inv;
    logic [MUL_P_W:0]     env_sum;
    logic [31:0]          env_new;
    logic [4:0]           sh;
    logic [31:0]          top_mask;
    logic                 top_zero;
    logic [15:0]          f_val;
    logic [16:0]          prod_hi;
    logic [15:0]          corr16;
    logic [16:0]          fp;
    logic [20:0]          log_int;
    logic [MUL_P_W-1:0]   db_round;
    logic [16:0]          db_mag;
    logic signed [17:0]   thr_ext;
    logic signed [17:0]   diff;
    logic [MUL_P_W-1:0]   g_round;
    logic [15:0]          g_mag;
    logic [14:0]          gm_sat;
    logic [MUL_P_W-1:0]   t_round;
    logic [19:0]          t_val;
    logic [16:0]          u_val;
    logic [17:0]          v_val;
    logic [18:0]          vsum;
    logic [18:0]          lin_full;
    logic [MUL_P_W-1:0]   o_round;
    logic [SB-1:0]        o_mag;
    logic [SB-1:0]        o_res;
    logic [SB-1:0]        in_mag;

    // envelope update terms
    assign coef_sel = (x_reg > env_reg) ? attack_coef : release_coef;
    assign coef_one = MUL_B_W'(1) << COEF_BITS;
    assign coef_inv = coef_one - MUL_B_W'(coef_sel);
    assign env_sum  = (MUL_P_W+1)'(acc_reg) + (MUL_P_W+1)'(prod)
                    + ((MUL_P_W+1)'(1) << (COEF_BITS-1));
    assign env_new  = env_sum[COEF_BITS +: 32];

    // binary normalize, 16/8/4/2/1
    assign sh       = 5'(5'd16 >> k_reg);
    assign top_mask = ~(32'hFFFF_FFFF >> sh);
    assign top_zero = (w_reg & top_mask) == 32'd0;

    // log2 and db terms
    assign f_val    = w_reg[30:15];
    assign prod_hi  = prod[32:16];
    assign corr16   = prod[31:16];
    assign fp       = 17'(f_val) + 17'(corr16);
    assign log_int  = {~p_reg, 16'd0};
    assign db_round = prod + (MUL_P_W'(1) << 23);
    assign db_mag   = db_round[40:24];

    // gain terms
    assign thr_ext  = {{2{threshold[15]}}, threshold};
    assign diff     = db_reg - thr_ext;
    assign g_round  = prod + MUL_P_W'(32768);
    assign g_mag    = g_round[31:16];
    assign gm_sat   = (g_mag > 16'(GAIN_MIN_MAG)) ? GAIN_MIN_MAG : g_mag[14:0];

    // exp terms
    assign t_round  = prod + MUL_P_W'(128);
    assign t_val    = t_round[27:8];
    assign u_val    = 17'h10000 - 17'(t_val[15:0]);
    assign v_val    = 18'h10000 + 18'(arg_reg[16:0]) - 18'(corr16);
    assign vsum     = 19'(v_val) + (19'(1) << (5'(n_reg) + 5'd1));
    assign lin_full = vsum >> (5'(n_reg) + 5'd2);

    // output scaling
    assign o_round  = prod + MUL_P_W'(16384);
    assign o_mag    = o_round[15 +: SB];
    assign o_res    = sign_reg ? (~o_mag + SB'(1)) : o_mag;

    assign in_mag   = s_data.sample_in[SB-1] ? (~s_data.sample_in + SB'(1))
                                             : s_data.sample_in;

    always_comb begin
        mul_req.en = 1'b0;
        mul_req.a  = '0;
        mul_req.b  = '0;
        case (state_reg)
            S_ENV0: begin
                mul_req.en = 1'b1;
                mul_req.a  = env_reg;
                mul_req.b  = MUL_B_W'(coef_sel);
            end
            S_ENV1: begin
                mul_req.en = 1'b1;
                mul_req.a  = x_reg;
                mul_req.b  = coef_inv;
            end
            S_LOG0: begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(f_val);
                mul_req.b  = MUL_B_W'(17'h10000 - 17'(f_val));
            end
            S_LOG1: begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(prod_hi);
                mul_req.b  = LOG_CORR;
            end
            S_LOG3: begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(arg_reg);
                mul_req.b  = DB_PER_LOG2;
            end
            S_GAIN1: begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(arg_reg);
                mul_req.b  = SLOPE_Q16;
            end
            S_EXP0: begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(arg_reg);
                mul_req.b  = LOG2_10_OVER_20;
            end
            S_EXP2: begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(arg_reg[16:0]);
                mul_req.b  = MUL_B_W'(17'h10000 - arg_reg[16:0]);
            end
            S_EXP3: begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(prod_hi);
                mul_req.b  = EXP_CORR;
            end
            S_OUT0: begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(mag_reg);
                mul_req.b  = MUL_B_W'(lin_reg);
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        env_next     = env_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        sign_next    = sign_reg;
        mag_next     = mag_reg;
        x_next       = x_reg;
        blk_next     = blk_reg;
        acc_next     = acc_reg;
        w_next       = w_reg;
        p_next       = p_reg;
        k_next       = k_reg;
        arg_next     = arg_reg;
        db_next      = db_reg;
        gain_next    = gain_reg;
        n_next       = n_reg;
        lin_next     = lin_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    sign_next  = s_data.sample_in[SB-1];
                    mag_next   = in_mag;
                    x_next     = 32'(in_mag) << ENV_SHIFT;
                    blk_next   = s_data.block_end;
                    state_next = S_ENV0;
                end
            end
            S_ENV0: state_next = S_ENV1;
            S_ENV1: begin
                acc_next   = prod;
                state_next = S_ENV2;
            end
            S_ENV2: begin
                env_next = env_new;
                if (env_new <= ENV_FLOOR) begin
                    db_next    = DB_FLOOR;
                    state_next = S_GAIN0;
                end else begin
                    w_next     = env_new;
                    p_next     = 5'd31;
                    k_next     = 3'd0;
                    state_next = S_NORM;
                end
            end
            S_NORM: begin
                if (top_zero) begin
                    w_next = w_reg << sh;
                    p_next = p_reg - sh;
                end
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd4) begin
                    state_next = S_LOG0;
                end
            end
            S_LOG0: state_next = S_LOG1;
            S_LOG1: state_next = S_LOG2;
            S_LOG2: begin
                if (21'(fp) >= log_int) begin
                    db_next    = 18'sd0;
                    state_next = S_GAIN0;
                end else begin
                    arg_next   = log_int - 21'(fp);
                    state_next = S_LOG3;
                end
            end
            S_LOG3: state_next = S_LOG4;
            S_LOG4: begin
                db_next    = $signed(18'd0 - {1'b0, db_mag});
                state_next = S_GAIN0;
            end
            S_GAIN0: begin
                if (db_reg > thr_ext) begin
                    arg_next   = 21'(diff[16:0]);
                    state_next = S_GAIN1;
                end else begin
                    gain_next  = 16'sd0;
                    lin_next   = LIN_UNITY;
                    state_next = S_OUT0;
                end
            end
            S_GAIN1: state_next = S_GAIN2;
            S_GAIN2: begin
                gain_next  = $signed(16'd0 - 16'(gm_sat));
                arg_next   = 21'(gm_sat);
                state_next = S_EXP0;
            end
            S_EXP0: state_next = S_EXP1;
            S_EXP1: begin
                n_next     = t_val[19:16];
                arg_next   = 21'(u_val);
                state_next = S_EXP2;
            end
            S_EXP2: state_next = S_EXP3;
            S_EXP3: state_next = S_EXP4;
            S_EXP4: begin
                lin_next   = lin_full[15:0];
                state_next = S_OUT0;
            end
            S_OUT0: state_next = S_OUT1;
            S_OUT1: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.sample_out    = $signed(o_res);
                    m_data_next.gain_db       = gain_reg;
                    m_data_next.block_end_out = blk_reg;
                    state_next                = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            env_reg     <= 32'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            env_reg     <= env_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        sign_reg   <= sign_next;
        mag_reg    <= mag_next;
        x_reg      <= x_next;
        blk_reg    <= blk_next;
        acc_reg    <= acc_next;
        w_reg      <= w_next;
        p_reg      <= p_next;
        k_reg      <= k_next;
        arg_reg    <= arg_next;
        db_reg     <= db_next;
        gain_reg   <= gain_next;
        n_reg      <= n_next;
        lin_reg    <= lin_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_ENV0))
        else $error("accepted beat did not start the envelope update");

    a_result_from_last_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == S_OUT1))
        else $error("result raised outside the final step");

    a_db_not_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_GAIN0) |-> (db_reg <= 18'sd0))
        else $error("envelope level above full scale");

    a_gain_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT0) |->
            (gain_reg <= 16'sd0 && gain_reg >= -16'sd24576 && lin_reg <= LIN_UNITY))
        else $error("gain or linear factor out of range");

endmodule

### rtl/audio_peak_limiter.sv
// audio_peak_limiter: feed-forward peak limiter, top level
// one beat at a time: the next beat waits until the last result is in m_data
// its steps follow the chain of dependent products through the one shared multiplier
// floor-level envelope is fastest; full limiting with a five-step normalize is slowest
// synchronous active-low reset: envelope zero, registers to defaults, output empty
// depends on apl_pkg, apl_regs, apl_mul, apl_seq
module audio_peak_limiter #(
    parameter int COEF_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  apl_pkg::apl_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output apl_pkg::apl_out_t               m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [apl_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import apl_pkg::*;

    logic signed [15:0]   threshold;
    logic [COEF_BITS-1:0] attack_coef;
    logic [COEF_BITS-1:0] release_coef;
    apl_mul_req_t         mul_req;
    logic [MUL_P_W-1:0]   prod;

    apl_regs #(
        .COEF_BITS (COEF_BITS)
    ) u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .threshold    (threshold),
        .attack_coef  (attack_coef),
        .release_coef (release_coef)
    );

    apl_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (prod)
    );

    apl_seq #(
        .COEF_BITS (COEF_BITS)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .threshold    (threshold),
        .attack_coef  (attack_coef),
        .release_coef (release_coef),
        .mul_req      (mul_req),
        .prod         (prod)
    );

endmodule
